/* rtl/core/qeit_pkg.sv */
// shared types, constants and helper functions of the quad edge intersection test
// no dependencies; every other file of the block but qeit_out_if uses it by scoped names

package qeit_pkg;

    // outline geometry
    localparam int CORNERS     = 4;
    localparam int CIDX_W      = $clog2(CORNERS);
    localparam int IDX_IN_W    = 2;
    localparam int SLOTS       = 8;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int ADDR_W      = SLOT_W + 1;
    localparam int STORE_DEPTH = 2 * SLOTS;

    // arithmetic widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int LO_W    = 12;
    localparam int HI_W    = DIFF_W - LO_W;
    localparam int PP_W    = DIFF_W + HI_W;
    localparam int PD_W    = PP_W + 1;
    localparam int CROSS_W = 2 * DIFF_W + 2;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] slot;
        point_t            pt;
        logic              evaluate;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    typedef struct packed {
        logic busy;
    } stat_t;

    typedef enum logic [1:0] {
        ORI_COL,
        ORI_CW,
        ORI_CCW
    } ori_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ROW,
        SEQ_PAIR,
        SEQ_DRAIN,
        SEQ_HOLD
    } seq_state_t;

    function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

    // m inside the bounding box of a and c, bounds included
    function automatic logic within_box(input point_t a, input point_t m, input point_t c);
        logic in_x;
        logic in_y;
        in_x = ((m.x <= a.x) || (m.x <= c.x)) && ((m.x >= a.x) || (m.x >= c.x));
        in_y = ((m.y <= a.y) || (m.y <= c.y)) && ((m.y >= a.y) || (m.y >= c.y));
        return in_x && in_y;
    endfunction

    function automatic ori_t ori_of(input logic signed [CROSS_W-1:0] v);
        ori_t o;
        if (v > 0)
        begin
            o = ORI_CW;
        end
        else if (v < 0)
        begin
            o = ORI_CCW;
        end
        else
        begin
            o = ORI_COL;
        end
        return o;
    endfunction

endpackage

/* rtl/core/qeit_in_if.sv */
// corner item channel: valid/ready handshake with the corner payload
// depends on qeit_pkg for field widths

interface qeit_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  shape_select;
    logic [qeit_pkg::IDX_IN_W-1:0]         corner_index;
    logic signed [qeit_pkg::COORD_W-1:0]   corner_x;
    logic signed [qeit_pkg::COORD_W-1:0]   corner_y;
    logic                                  evaluate;

    modport source (
        output valid, shape_select, corner_index, corner_x, corner_y, evaluate,
        input  ready
    );

    modport sink (
        input  valid, shape_select, corner_index, corner_x, corner_y, evaluate,
        output ready
    );
endinterface

/* rtl/core/qeit_out_if.sv */
// result channel: valid/ready handshake carrying the collision flag
// no dependencies

interface qeit_out_if;
    logic valid;
    logic ready;
    logic colliding;

    modport source (
        output valid, colliding,
        input  ready
    );

    modport sink (
        input  valid, colliding,
        output ready
    );
endinterface

/* rtl/core/qeit_front.sv */
// front end: takes corner items, turns them into store/evaluate commands
// and holds them in a short queue for the back end; uses qeit_pkg, qeit_in_if

module qeit_front (
    input  logic             clk,
    input  logic             rst_n,
    qeit_in_if.sink          item,
    output logic             cmd_valid,
    output qeit_pkg::cmd_t   cmd,
    input  logic             cmd_pop
);

    qeit_pkg::cmd_t                  q_mem [qeit_pkg::QDEPTH];
    qeit_pkg::cmd_t                  cls;
    logic [qeit_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [qeit_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [qeit_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [qeit_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [qeit_pkg::QCNT_W-1:0]     count_reg;
    logic [qeit_pkg::QCNT_W-1:0]     count_next;
    logic                            push;

    assign item.ready = (count_reg != qeit_pkg::QCNT_W'(qeit_pkg::QDEPTH));
    assign push       = item.valid && item.ready;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = q_mem[rd_ptr_reg];

    // an index past the outline only skips the store
    always_comb
    begin
        cls.wr_en    = (32'(item.corner_index) < qeit_pkg::CORNERS);
        cls.slot     = {item.shape_select, qeit_pkg::SLOT_W'(item.corner_index)};
        cls.pt.x     = item.corner_x;
        cls.pt.y     = item.corner_y;
        cls.evaluate = item.evaluate;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == qeit_pkg::QPTR_W'(qeit_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == qeit_pkg::QPTR_W'(qeit_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* rtl/core/qeit_edge_pipe.sv */
// edge pair test pipeline: differences, split partial products, cross sum,
// orientation signs and box checks; one edge pair enters per cycle; uses qeit_pkg

module qeit_edge_pipe (
    input  logic             clk,
    input  logic             rst_n,
    input  qeit_pkg::tag_t   in_tag,
    input  qeit_pkg::point_t p1,
    input  qeit_pkg::point_t q1,
    input  qeit_pkg::point_t p2,
    input  qeit_pkg::point_t q2,
    output qeit_pkg::tag_t   out_tag,
    output logic             touch
);

    // four orientation tests: o = m0*m1 - n0*n1
    qeit_pkg::point_t                    pa [4];
    qeit_pkg::point_t                    pb [4];
    qeit_pkg::point_t                    pc [4];

    logic signed [qeit_pkg::DIFF_W-1:0]  m0_next [4];
    logic signed [qeit_pkg::DIFF_W-1:0]  m1_next [4];
    logic signed [qeit_pkg::DIFF_W-1:0]  n0_next [4];
    logic signed [qeit_pkg::DIFF_W-1:0]  n1_next [4];
    logic [3:0]                          box_d_next;
    logic signed [qeit_pkg::DIFF_W-1:0]  m0_reg [4];
    logic signed [qeit_pkg::DIFF_W-1:0]  m1_reg [4];
    logic signed [qeit_pkg::DIFF_W-1:0]  n0_reg [4];
    logic signed [qeit_pkg::DIFF_W-1:0]  n1_reg [4];
    logic [3:0]                          box_d_reg;
    qeit_pkg::tag_t                      tag_d_reg;

    logic signed [qeit_pkg::PP_W-1:0]    phm_next [4];
    logic signed [qeit_pkg::PP_W-1:0]    plm_next [4];
    logic signed [qeit_pkg::PP_W-1:0]    phn_next [4];
    logic signed [qeit_pkg::PP_W-1:0]    pln_next [4];
    logic signed [qeit_pkg::PP_W-1:0]    phm_reg [4];
    logic signed [qeit_pkg::PP_W-1:0]    plm_reg [4];
    logic signed [qeit_pkg::PP_W-1:0]    phn_reg [4];
    logic signed [qeit_pkg::PP_W-1:0]    pln_reg [4];
    logic [3:0]                          box_p_reg;
    qeit_pkg::tag_t                      tag_p_reg;

    logic signed [qeit_pkg::PD_W-1:0]    dh_next [4];
    logic signed [qeit_pkg::PD_W-1:0]    dl_next [4];
    logic signed [qeit_pkg::PD_W-1:0]    dh_reg [4];
    logic signed [qeit_pkg::PD_W-1:0]    dl_reg [4];
    logic [3:0]                          box_c_reg;
    qeit_pkg::tag_t                      tag_c_reg;

    qeit_pkg::ori_t                      ori_next [4];
    qeit_pkg::ori_t                      ori_reg [4];
    logic [3:0]                          box_s_reg;
    qeit_pkg::tag_t                      tag_s_reg;

    assign pa[0] = p1;
    assign pb[0] = q1;
    assign pc[0] = p2;
    assign pa[1] = p1;
    assign pb[1] = q1;
    assign pc[1] = q2;
    assign pa[2] = p2;
    assign pb[2] = q2;
    assign pc[2] = p1;
    assign pa[3] = p2;
    assign pb[3] = q2;
    assign pc[3] = q1;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            m0_next[k]    = qeit_pkg::sx(pb[k].y) - qeit_pkg::sx(pa[k].y);
            m1_next[k]    = qeit_pkg::sx(pc[k].x) - qeit_pkg::sx(pb[k].x);
            n0_next[k]    = qeit_pkg::sx(pb[k].x) - qeit_pkg::sx(pa[k].x);
            n1_next[k]    = qeit_pkg::sx(pc[k].y) - qeit_pkg::sx(pb[k].y);
            // the third point checked against the box of the tested edge
            box_d_next[k] = qeit_pkg::within_box(pa[k], pc[k], pb[k]);
        end
    end

    // multiplier split: second factor as signed high part and unsigned low part
    always_comb
    begin
        logic signed [qeit_pkg::HI_W-1:0]  hm;
        logic signed [qeit_pkg::HI_W-1:0]  hn;
        logic signed [qeit_pkg::LO_W:0]    lm;
        logic signed [qeit_pkg::LO_W:0]    ln;
        for (int k = 0; k < 4; k++)
        begin
            hm          = $signed(m1_reg[k][qeit_pkg::DIFF_W-1:qeit_pkg::LO_W]);
            hn          = $signed(n1_reg[k][qeit_pkg::DIFF_W-1:qeit_pkg::LO_W]);
            lm          = $signed({1'b0, m1_reg[k][qeit_pkg::LO_W-1:0]});
            ln          = $signed({1'b0, n1_reg[k][qeit_pkg::LO_W-1:0]});
            phm_next[k] = qeit_pkg::PP_W'(m0_reg[k]) * qeit_pkg::PP_W'(hm);
            plm_next[k] = qeit_pkg::PP_W'(m0_reg[k]) * qeit_pkg::PP_W'(lm);
            phn_next[k] = qeit_pkg::PP_W'(n0_reg[k]) * qeit_pkg::PP_W'(hn);
            pln_next[k] = qeit_pkg::PP_W'(n0_reg[k]) * qeit_pkg::PP_W'(ln);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            dh_next[k] = qeit_pkg::PD_W'(phm_reg[k]) - qeit_pkg::PD_W'(phn_reg[k]);
            dl_next[k] = qeit_pkg::PD_W'(plm_reg[k]) - qeit_pkg::PD_W'(pln_reg[k]);
        end
    end

    always_comb
    begin
        logic signed [qeit_pkg::CROSS_W-1:0] v;
        for (int k = 0; k < 4; k++)
        begin
            v = (qeit_pkg::CROSS_W'(dh_reg[k]) <<< qeit_pkg::LO_W) +
                qeit_pkg::CROSS_W'(dl_reg[k]);
            ori_next[k] = qeit_pkg::ori_of(v);
        end
    end

    // proper crossing, or a collinear endpoint inside the other edge's box
    assign touch = ((ori_reg[0] != ori_reg[1]) && (ori_reg[2] != ori_reg[3])) ||
                   ((ori_reg[0] == qeit_pkg::ORI_COL) && box_s_reg[0]) ||
                   ((ori_reg[1] == qeit_pkg::ORI_COL) && box_s_reg[1]) ||
                   ((ori_reg[2] == qeit_pkg::ORI_COL) && box_s_reg[2]) ||
                   ((ori_reg[3] == qeit_pkg::ORI_COL) && box_s_reg[3]);
    assign out_tag = tag_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d_reg <= '0;
            tag_p_reg <= '0;
            tag_c_reg <= '0;
            tag_s_reg <= '0;
        end
        else
        begin
            tag_d_reg <= in_tag;
            tag_p_reg <= tag_d_reg;
            tag_c_reg <= tag_p_reg;
            tag_s_reg <= tag_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        box_d_reg <= box_d_next;
        box_p_reg <= box_d_reg;
        box_c_reg <= box_p_reg;
        box_s_reg <= box_c_reg;
        for (int k = 0; k < 4; k++)
        begin
            m0_reg[k]  <= m0_next[k];
            m1_reg[k]  <= m1_next[k];
            n0_reg[k]  <= n0_next[k];
            n1_reg[k]  <= n1_next[k];
            phm_reg[k] <= phm_next[k];
            plm_reg[k] <= plm_next[k];
            phn_reg[k] <= phn_next[k];
            pln_reg[k] <= pln_next[k];
            dh_reg[k]  <= dh_next[k];
            dl_reg[k]  <= dl_next[k];
            ori_reg[k] <= ori_next[k];
        end
    end

endmodule

/* rtl/core/qeit_back.sv */
// back end: corner store, edge pair sequencer, collision accumulator and
// result register; uses qeit_pkg, qeit_out_if, qeit_edge_pipe

module qeit_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  qeit_pkg::cmd_t   cmd,
    output logic             cmd_pop,
    output qeit_pkg::stat_t  stat,
    qeit_out_if.source       result
);

    qeit_pkg::point_t                store [qeit_pkg::STORE_DEPTH];

    qeit_pkg::seq_state_t            state_reg;
    qeit_pkg::seq_state_t            state_next;
    logic [qeit_pkg::CIDX_W-1:0]     i_reg;
    logic [qeit_pkg::CIDX_W-1:0]     i_next;
    logic [qeit_pkg::CIDX_W-1:0]     j_reg;
    logic [qeit_pkg::CIDX_W-1:0]     j_next;
    logic [qeit_pkg::CIDX_W-1:0]     ni;
    logic [qeit_pkg::CIDX_W-1:0]     nj;
    logic                            i_last;
    logic                            j_last;
    logic                            acc_reg;
    logic                            acc_next;

    logic                            mem_we;
    logic [qeit_pkg::ADDR_W-1:0]     rd_addr_a;
    logic [qeit_pkg::ADDR_W-1:0]     rd_addr_b;
    qeit_pkg::point_t                rd_a_reg;
    qeit_pkg::point_t                rd_b_reg;
    qeit_pkg::tag_t                  issue_tag;
    qeit_pkg::tag_t                  rd_tag_reg;
    logic                            row_issue;
    logic                            row_ld_reg;
    qeit_pkg::point_t                p1_reg;
    qeit_pkg::point_t                q1_reg;

    qeit_pkg::tag_t                  pipe_tag;
    logic                            pipe_touch;
    logic                            pipe_done;

    logic                            slot_free;
    logic                            out_load;
    logic                            out_value;
    logic                            res_valid_reg;
    logic                            res_valid_next;
    logic                            res_coll_reg;

    assign i_last    = (i_reg == qeit_pkg::CIDX_W'(qeit_pkg::CORNERS - 1));
    assign j_last    = (j_reg == qeit_pkg::CIDX_W'(qeit_pkg::CORNERS - 1));
    assign ni        = i_last ? '0 : i_reg + 1'b1;
    assign nj        = j_last ? '0 : j_reg + 1'b1;
    assign slot_free = !res_valid_reg || result.ready;
    assign pipe_done = pipe_tag.valid && pipe_tag.last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qeit_pkg::SEQ_IDLE:
            begin
                if (cmd_valid && cmd.evaluate)
                begin
                    state_next = qeit_pkg::SEQ_ROW;
                end
            end
            qeit_pkg::SEQ_ROW:
            begin
                state_next = qeit_pkg::SEQ_PAIR;
            end
            qeit_pkg::SEQ_PAIR:
            begin
                if (j_last)
                begin
                    state_next = i_last ? qeit_pkg::SEQ_DRAIN : qeit_pkg::SEQ_ROW;
                end
            end
            qeit_pkg::SEQ_DRAIN:
            begin
                if (pipe_done)
                begin
                    state_next = slot_free ? qeit_pkg::SEQ_IDLE : qeit_pkg::SEQ_HOLD;
                end
            end
            qeit_pkg::SEQ_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = qeit_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = qeit_pkg::SEQ_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_pop   = 1'b0;
        mem_we    = 1'b0;
        row_issue = 1'b0;
        issue_tag = '0;
        out_load  = 1'b0;
        out_value = acc_reg | pipe_touch;
        rd_addr_a = {1'b1, qeit_pkg::SLOT_W'(j_reg)};
        rd_addr_b = {1'b1, qeit_pkg::SLOT_W'(nj)};
        unique case (state_reg)
            qeit_pkg::SEQ_IDLE:
            begin
                cmd_pop = cmd_valid;
                mem_we  = cmd_valid && cmd.wr_en;
            end
            qeit_pkg::SEQ_ROW:
            begin
                row_issue = 1'b1;
                rd_addr_a = {1'b0, qeit_pkg::SLOT_W'(i_reg)};
                rd_addr_b = {1'b0, qeit_pkg::SLOT_W'(ni)};
            end
            qeit_pkg::SEQ_PAIR:
            begin
                issue_tag.valid = 1'b1;
                issue_tag.last  = i_last && j_last;
            end
            qeit_pkg::SEQ_DRAIN:
            begin
                out_load = pipe_done && slot_free;
            end
            qeit_pkg::SEQ_HOLD:
            begin
                out_load  = slot_free;
                out_value = acc_reg;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        i_next   = i_reg;
        j_next   = j_reg;
        acc_next = acc_reg;
        if (state_reg == qeit_pkg::SEQ_IDLE)
        begin
            i_next   = '0;
            j_next   = '0;
            acc_next = 1'b0;
        end
        else
        begin
            if (state_reg == qeit_pkg::SEQ_PAIR)
            begin
                j_next = nj;
                if (j_last)
                begin
                    i_next = ni;
                end
            end
            if (pipe_tag.valid)
            begin
                acc_next = acc_reg | pipe_touch;
            end
        end
    end

    assign res_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qeit_pkg::SEQ_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            acc_reg       <= 1'b0;
            rd_tag_reg    <= '0;
            row_ld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            acc_reg       <= acc_next;
            rd_tag_reg    <= issue_tag;
            row_ld_reg    <= row_issue;
            res_valid_reg <= res_valid_next;
        end
    end

    // corner store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[cmd.slot] <= cmd.pt;
        end
        rd_a_reg <= store[rd_addr_a];
        rd_b_reg <= store[rd_addr_b];
    end

    // first-shape edge held for a whole row of pairs
    always_ff @(posedge clk)
    begin
        if (row_ld_reg)
        begin
            p1_reg <= rd_a_reg;
            q1_reg <= rd_b_reg;
        end
        if (out_load)
        begin
            res_coll_reg <= out_value;
        end
    end

    qeit_edge_pipe u_edge_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (rd_tag_reg),
        .p1      (p1_reg),
        .q1      (q1_reg),
        .p2      (rd_a_reg),
        .q2      (rd_b_reg),
        .out_tag (pipe_tag),
        .touch   (pipe_touch)
    );

    assign stat.busy        = (state_reg != qeit_pkg::SEQ_IDLE);
    assign result.valid     = res_valid_reg;
    assign result.colliding = res_coll_reg;

endmodule

/* rtl/core/quad_edge_intersection_test.sv */
// top level of the quad edge intersection test: front end, command queue,
// back end with corner store and edge pair pipeline; uses qeit_pkg and both interfaces
//
//  channel  | dir | payload                                                  | transfer
//  ---------+-----+----------------------------------------------------------+-------------
//  item     | in  | shape_select, corner_index, corner_x, corner_y, evaluate | valid&ready
//  result   | out | colliding                                                | valid&ready
//
// a corner item is written to the corner store at the edge it leaves the two-entry queue,
// which happens once the back is idle; an evaluation walks CORNERS rows of one edge load plus
// CORNERS pair reads, then drains the five-stage read and cross product pipeline
// reset clears queue, sequencer and result valid; the corner store holds junk until written
// up to two items queue up while the back evaluates or a result waits, then the input stalls

module quad_edge_intersection_test (
    input  logic        clk,
    input  logic        rst_n,
    qeit_in_if.sink     item,
    qeit_out_if.source  result
);

    logic             cmd_valid;
    qeit_pkg::cmd_t   cmd;
    logic             cmd_pop;
    qeit_pkg::stat_t  stat;

    qeit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    qeit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .stat      (stat),
        .result    (result)
    );

    // an empty queue always has room for a transfer
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> item.ready)
        else $error("queue empty but item not ready");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // store writes and new commands stay out of a running evaluation
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !cmd_pop)
        else $error("command popped during evaluation");

endmodule
